@@ src/vertex_weld_table_macros.svh @@
// Assertion helpers for the top level, which checks its own logic.
`ifndef VERTEX_WELD_TABLE_MACROS_SVH
`define VERTEX_WELD_TABLE_MACROS_SVH

// Antecedent holds, so the consequent holds in the same cycle.
`define VWT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex weld table check failed");

// Antecedent holds, so the consequent holds in the next cycle.
`define VWT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex weld table check failed");

`endif

@@ src/vwt_pkg.sv @@
package vwt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COORD_W     = 32;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int IDX_W       = 10;
    localparam int TOL_W       = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(17);
    localparam logic             MODE_MERGE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic issue;
        logic emit_hit;
        logic append;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic all_issued;
        logic pipe_busy;
        logic hit;
    } t_dp_status;

endpackage

@@ src/vertex_weld_table.sv @@
// Channel   Handshake                    Fields
// input     start, busy                  i_mode, i_coord_x, i_coord_y
// result    o_valid (one-cycle strobe)   o_point_index, o_was_found, o_table_full
// config    i_cfg_we                     i_cfg_wdata (match tolerance)
//
// A preload item goes from start through the append state to its result. A
// merge item scans the stored points through the single read port of the point
// memory, one entry a cycle, and then appends the point on a miss; a hit stops
// the scan early and gives the index of the matching entry as its result.
// Reset is synchronous and active low; it empties the store and restores the
// tolerance. The memory itself is not cleared. The receiver cannot stall.
module vertex_weld_table
    import vwt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_mode,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic                      i_cfg_we,
    input  logic [TOL_W-1:0]          i_cfg_wdata,
    output logic                      o_valid,
    output logic [IDX_W-1:0]          o_point_index,
    output logic                      o_was_found,
    output logic                      o_table_full
);

`include "vertex_weld_table_macros.svh"

    t_dp_cmd    cmd;
    t_dp_status status;

    vwt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    vwt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_point_index (o_point_index),
        .o_was_found   (o_was_found),
        .o_table_full  (o_table_full)
    );

    // A point that matched was never also refused for lack of room.
    `VWT_ASSERT_SAME(a_found_not_full, i_clk, i_rst_n, o_valid, !(o_was_found && o_table_full))
    // An accepted item keeps the block busy until its result is out.
    `VWT_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // The result appears exactly as the block goes idle again.
    `VWT_ASSERT_SAME(a_done_result, i_clk, i_rst_n, $fell(busy), o_valid)
    // Results never come in consecutive cycles.
    `VWT_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)

endmodule

@@ src/vwt_ctrl.sv @@
module vwt_ctrl
    import vwt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_mode,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_mode == MODE_MERGE) ? ST_SCAN : ST_APPEND;
                end
            end
            ST_SCAN: begin
                if (i_status.hit) begin
                    n_state = ST_IDLE;
                end else if (i_status.all_issued && !i_status.pipe_busy) begin
                    n_state = ST_APPEND;
                end
            end
            ST_APPEND: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_SCAN: begin
                // Reads already in flight past a hit are simply dropped.
                o_cmd.emit_hit = i_status.hit;
                o_cmd.issue    = !i_status.all_issued && !i_status.hit;
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

@@ src/vwt_datapath.sv @@
module vwt_datapath
    import vwt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [TOL_W-1:0]          i_cfg_wdata,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    output logic                      o_valid,
    output logic [IDX_W-1:0]          o_point_index,
    output logic                      o_was_found,
    output logic                      o_table_full
);

    logic [COORD_W-1:0] mem_x [TABLE_DEPTH];
    logic [COORD_W-1:0] mem_y [TABLE_DEPTH];

    logic [TOL_W-1:0]          r_tol;
    logic [CNT_W-1:0]          r_count;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic [CNT_W-1:0]          r_scan_idx;

    // Read stage and difference stage of the scan pipeline.
    logic                      r_rd_vld;
    logic [ADDR_W-1:0]         r_rd_idx;
    logic signed [COORD_W-1:0] r_rd_x;
    logic signed [COORD_W-1:0] r_rd_y;
    logic                      r_d_vld;
    logic [ADDR_W-1:0]         r_d_idx;
    logic signed [DIFF_W-1:0]  r_dx;
    logic signed [DIFF_W-1:0]  r_dy;

    logic                      r_valid;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_found;
    logic                      r_full;

    logic signed [DIFF_W-1:0]  n_dx;
    logic signed [DIFF_W-1:0]  n_dy;
    logic signed [DIFF_W-1:0]  tol_pos;
    logic signed [DIFF_W-1:0]  tol_neg;
    logic                      full;
    logic                      hit;

    assign n_dx = DIFF_W'(r_x) - DIFF_W'(r_rd_x);
    assign n_dy = DIFF_W'(r_y) - DIFF_W'(r_rd_y);

    assign tol_pos = $signed({{(DIFF_W-TOL_W){1'b0}}, r_tol});
    assign tol_neg = -tol_pos;

    assign hit  = r_d_vld && (r_dx <= tol_pos) && (r_dx >= tol_neg)
                          && (r_dy <= tol_pos) && (r_dy >= tol_neg);
    assign full = (r_count == CNT_W'(TABLE_DEPTH));

    assign o_status.all_issued = (r_scan_idx == r_count);
    assign o_status.pipe_busy  = r_rd_vld || r_d_vld;
    assign o_status.hit        = hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_RESET;
            r_count <= '0;
            r_valid <= 1'b0;
            r_rd_vld <= 1'b0;
            r_d_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            r_valid <= i_cmd.emit_hit || i_cmd.append;
            if (i_cmd.load) begin
                r_rd_vld <= 1'b0;
                r_d_vld  <= 1'b0;
            end else begin
                r_rd_vld <= i_cmd.issue;
                r_d_vld  <= r_rd_vld;
            end
            if (i_cmd.append && !full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x        <= i_coord_x;
            r_y        <= i_coord_y;
            r_scan_idx <= '0;
        end else if (i_cmd.issue) begin
            r_scan_idx <= r_scan_idx + CNT_W'(1);
        end
        if (i_cmd.issue) begin
            r_rd_x   <= mem_x[r_scan_idx[ADDR_W-1:0]];
            r_rd_y   <= mem_y[r_scan_idx[ADDR_W-1:0]];
            r_rd_idx <= r_scan_idx[ADDR_W-1:0];
        end
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_d_idx <= r_rd_idx;
        if (i_cmd.append && !full) begin
            mem_x[r_count[ADDR_W-1:0]] <= r_x;
            mem_y[r_count[ADDR_W-1:0]] <= r_y;
        end
        if (i_cmd.emit_hit) begin
            r_idx   <= IDX_W'(r_d_idx);
            r_found <= 1'b1;
            r_full  <= 1'b0;
        end else if (i_cmd.append) begin
            r_idx   <= full ? '0 : IDX_W'(r_count);
            r_found <= 1'b0;
            r_full  <= full;
        end
    end

    assign o_valid       = r_valid;
    assign o_point_index = r_idx;
    assign o_was_found   = r_found;
    assign o_table_full  = r_full;

endmodule
